@@ hdl/emhq_pkg.sv @@
`default_nettype none

package emhq_pkg;

   // Keys are stored with the sign bit flipped so that an unsigned compare orders them.
   localparam logic [31:0] KEY_BIAS = 32'h8000_0000;
   localparam logic [31:0] B_MIN    = 32'h0000_0000;
   localparam logic [31:0] B_MAX    = 32'hFFFF_FFFF;
   localparam int          ARITY    = 8;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD0,
      ST_POP_MIN,
      ST_POP_LAST,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } emhq_state_type;

   // Running minimum handed from one lane cell to the next.
   typedef struct packed {
      logic [31:0] val;
      logic [2:0]  lane;
   } emhq_best_type;

   // Write request for one lane cell.
   typedef struct packed {
      logic        we;
      logic [31:0] data;
   } emhq_wr_type;

   // Cells are chained in the lane order 0,4,1,5,2,6,3,7.
   function automatic logic [2:0] chain_lane(input logic [2:0] pos);
      chain_lane = {pos[0], pos[2:1]};
   endfunction

endpackage

`default_nettype wire

@@ hdl/emhq_lane_cell.sv @@
`default_nettype none

module emhq_lane_cell import emhq_pkg::*; #(
   parameter int ROWS  = 512,
   parameter int SLOTS = 4096,
   parameter int LANE  = 0,
   parameter int RW    = 9
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [RW-1:0] rd_row,
   input  wire logic [RW-1:0] wr_row,
   input  wire emhq_wr_type   wr,
   input  wire emhq_best_type best_in,
   output emhq_best_type      best_out,
   output logic [31:0]        rd_data
);

   logic [31:0]   mem [ROWS];
   logic [31:0]   rd_data_ff;
   logic [RW-1:0] rd_row_ff;
   logic [31:0]   slot_idx;
   logic [31:0]   cand;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_row] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
         rd_row_ff  <= rd_row;
      end
   end

   assign rd_data  = rd_data_ff;
   assign slot_idx = {(32 - RW - 3)'(0), rd_row_ff, 3'(LANE)};

   // The sentinel slot and slots past the end of the store count as empty here.
   always_comb begin
      if (slot_idx == 32'd0 || slot_idx >= 32'(SLOTS)) begin
         cand = B_MAX;
      end else begin
         cand = rd_data_ff;
      end
      if (best_in.val > cand) begin
         best_out.val  = cand;
         best_out.lane = 3'(LANE);
      end else begin
         best_out = best_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/eight_ary_min_heap_queue.sv @@
// A push reads one parent row and compares per level climbed; a pop reads the top row and
// the last key's row, then sifts down unless the popped slot was the last one; a rejected
// request goes straight to the response.
// Throughput: one request at a time; each heap level costs one row read and one compare/write.
// Reset is synchronous and active high; afterwards a clearing pass writes every row of the
// slot store before the first request is taken.
`default_nettype none

module eight_ary_min_heap_queue import emhq_pkg::*; #(
   parameter int HEAP_SLOTS = 4096,
   parameter int MAX_KEYS   = 511
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [0] func, [32:1] key_in, [39:33] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // [31:0] key_out, [33:32] status,
                                         // [42:34] occupancy, [47:43] zero
);

   // The store is kept as rows of eight slots; row r holds slots 8r to 8r+7, which
   // are exactly the children of slot r. Each of the eight lane cells holds one
   // column of rows, and the cells pass the running minimum of a row down the chain.
   localparam int NROWS = (HEAP_SLOTS + 7) / 8;
   localparam int RW    = $clog2(NROWS);
   localparam int SW    = RW + 3;
   localparam int CW    = $clog2(MAX_KEYS + 1);

   emhq_state_type state_ff, state_in;

   logic [RW-1:0] clr_row_ff, clr_row_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   key_ff, key_in_b;
   logic [SW-1:0] idx_ff, idx_in;
   logic [31:0]   moved_ff, moved_in;
   logic [31:0]   res_ff, res_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic          req_func;
   logic [31:0]   count_ext;
   logic          full;
   logic [SW-1:0] par_slot;
   logic [SW-1:0] last_slot;
   logic [31:0]   par_val;
   logic [31:0]   last_val;
   logic          resp_free;

   logic          rd_en;
   logic [RW-1:0] rd_row;
   logic          wr_en;
   logic [SW-1:0] wr_slot;
   logic [31:0]   wr_val;

   emhq_wr_type   wr_vec [8];
   logic [31:0]   lane_data [8];
   emhq_best_type best [9];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_func   = req_tdata[0];
   assign key_in_b   = req_tdata[32:1] ^ KEY_BIAS;
   assign count_ext  = 32'(count_ff);
   assign full       = (count_ext >= 32'(MAX_KEYS)) || (count_ext + 32'd1 >= 32'(HEAP_SLOTS));
   assign par_slot   = idx_ff >> 3;
   assign last_slot  = SW'(count_ext);
   assign par_val    = lane_data[par_slot[2:0]];
   assign last_val   = lane_data[last_slot[2:0]];
   assign resp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Lane cells, chained so the minimum of a row leaves the last cell.
   assign best[0] = '{val: B_MAX, lane: 3'd0};

   for (genvar c = 0; c < 8; c++) begin : g_cell
      localparam logic [2:0] LN = chain_lane(3'(c));
      emhq_lane_cell #(
         .ROWS  (NROWS),
         .SLOTS (HEAP_SLOTS),
         .LANE  (int'(LN)),
         .RW    (RW)
      ) u_cell (
         .clock    (clock),
         .rd_en    (rd_en),
         .rd_row   (rd_row),
         .wr_row   ((state_ff == ST_CLEAR) ? clr_row_ff : wr_slot[SW-1:3]),
         .wr       (wr_vec[LN]),
         .best_in  (best[c]),
         .best_out (best[c+1]),
         .rd_data  (lane_data[LN])
      );
   end

   // At most one slot write per cycle, except during the clearing pass, which writes a whole
   // row: all slots empty, with the sentinel slot 0 holding the minimum.
   always_comb begin
      for (int l = 0; l < 8; l++) begin
         if (state_ff == ST_CLEAR) begin
            wr_vec[l].we   = 1'b1;
            wr_vec[l].data = (clr_row_ff == '0 && l == 0) ? B_MIN : B_MAX;
         end else begin
            wr_vec[l].we   = wr_en && (wr_slot[2:0] == 3'(l));
            wr_vec[l].data = wr_val;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == RW'(NROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_func == FUNC_PUSH) begin
                  state_in = full ? ST_RESP : ST_UP_RD;
               end else begin
                  state_in = (count_ff == '0) ? ST_RESP : ST_POP_RD0;
               end
            end
         end
         ST_UP_RD: state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            state_in = (par_val > key_ff) ? ST_UP_RD : ST_RESP;
         end
         ST_POP_RD0:  state_in = ST_POP_MIN;
         ST_POP_MIN:  state_in = ST_POP_LAST;
         ST_POP_LAST: begin
            state_in = (32'(idx_ff) == count_ext) ? ST_RESP : ST_DN_RD;
         end
         ST_DN_RD: begin
            state_in = (32'(idx_ff) >= 32'(NROWS)) ? ST_RESP : ST_DN_CMP;
         end
         ST_DN_CMP: begin
            state_in = (best[8].val < moved_ff) ? ST_DN_RD : ST_RESP;
         end
         ST_RESP: begin
            if (resp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      clr_row_in   = clr_row_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      moved_in     = moved_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_row       = '0;
      wr_en        = 1'b0;
      wr_slot      = idx_ff;
      wr_val       = moved_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + RW'(1);
         end
         ST_IDLE: begin
            res_in    = B_MAX;
            status_in = STAT_OK;
            if (req_fire) begin
               if (req_func == FUNC_PUSH) begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                     idx_in   = SW'(count_ext + 32'd1);
                  end
               end else if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end
            end
         end
         ST_UP_RD: begin
            // Fetch the row that holds the parent of the slot being filled.
            rd_en  = 1'b1;
            rd_row = par_slot[SW-1:3];
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (par_val > key_ff) begin
               wr_val = par_val;
               idx_in = par_slot;
            end else begin
               wr_val = key_ff;
            end
         end
         ST_POP_RD0: begin
            rd_en  = 1'b1;
            rd_row = '0;
         end
         ST_POP_MIN: begin
            // The top level is slots 1 to 7; the winner's slot becomes the hole.
            res_in = best[8].val;
            idx_in = SW'(best[8].lane);
            rd_en  = 1'b1;
            rd_row = last_slot[SW-1:3];
         end
         ST_POP_LAST: begin
            // Pull the last key out and mark its slot empty before sifting down.
            moved_in = last_val;
            wr_en    = 1'b1;
            wr_slot  = last_slot;
            wr_val   = B_MAX;
            count_in = count_ff - CW'(1);
         end
         ST_DN_RD: begin
            if (32'(idx_ff) >= 32'(NROWS)) begin
               wr_en = 1'b1;
            end else begin
               rd_en  = 1'b1;
               rd_row = idx_ff[RW-1:0];
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (best[8].val < moved_ff) begin
               wr_val = best[8].val;
               idx_in = {idx_ff[RW-1:0], best[8].lane};
            end
         end
         ST_RESP: begin
            if (resp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, 9'(count_ext), status_ff, res_ff ^ KEY_BIAS};
            end
         end
         default: begin
            clr_row_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         key_ff <= key_in_b;
      end
      idx_ff      <= idx_in;
      moved_ff    <= moved_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ hdl/emhq_checker.sv @@
`default_nettype none

module emhq_checker import emhq_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Only one request is in flight at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("undefined status code");

   // Rejected requests return the maximum key.
   a_err_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != STAT_OK |-> rsp_tdata[31:0] == 32'h7FFF_FFFF)
      else $error("error response carries a key");

endmodule

bind eight_ary_min_heap_queue emhq_checker u_emhq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
